FILE: rtl/ccrc_pkg.sv
// Shared types, codes and helper functions for the configurable CRC engine.
// No dependencies; every other file imports this package.
`default_nettype none

package ccrc_pkg;

  localparam int unsigned CrcW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned StatusW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH_SELECT   = 3'd0,
    REG_GENERATOR_POLY = 3'd1,
    REG_START_VALUE    = 3'd2,
    REG_OUT_XOR        = 3'd3,
    REG_REFLECT_IN     = 3'd4,
    REG_REFLECT_OUT    = 3'd5
  } ccrc_reg_e;

  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_32 = 2'd2
  } ccrc_width_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_ZERO_POLY = 3'd1,
    STATUS_POLY_WIDE = 3'd2,
    STATUS_INIT_WIDE = 3'd3,
    STATUS_XOR_WIDE  = 3'd4
  } ccrc_status_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } ccrc_in_t;

  typedef struct packed {
    logic [CrcW-1:0]    crc_value;
    logic [StatusW-1:0] config_status;
  } ccrc_out_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } ccrc_item_t;

  // Active configuration as the back sees it.
  typedef struct packed {
    logic [1:0]      width_sel;
    logic [CrcW-1:0] mask;
    logic [CrcW-1:0] poly;
    logic [CrcW-1:0] init;
    logic [CrcW-1:0] xor_out;
    logic            reflect_out;
    ccrc_status_e    status;
  } ccrc_cfg_t;

  function automatic logic [CrcW-1:0] width_mask(input logic [1:0] width_sel);
    logic [CrcW-1:0] m;
    case (width_sel)
      WIDTH_8:  m = 32'h0000_00FF;
      WIDTH_16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ccrc_front.sv
// Front of the CRC engine: configuration registers, configuration check and
// input byte reflection ahead of the queue. Depends on ccrc_pkg.
`default_nettype none

module ccrc_front import ccrc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CrcW-1:0]    cfg_data_i,
  input  wire ccrc_in_t           in_data_i,
  output ccrc_item_t              item_o,
  output ccrc_cfg_t               cfg_o
);

  logic [1:0]      width_sel_q;
  logic [CrcW-1:0] poly_q;
  logic [CrcW-1:0] init_q;
  logic [CrcW-1:0] xor_q;
  logic            refl_in_q;
  logic            refl_out_q;
  logic [CrcW-1:0] mask;
  logic [ByteW-1:0] rev_byte;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_sel_q <= WIDTH_16;
      poly_q      <= 32'h0000_1021;
      init_q      <= '0;
      xor_q       <= '0;
      refl_in_q   <= 1'b0;
      refl_out_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WIDTH_SELECT:   width_sel_q <= cfg_data_i[1:0];
        REG_GENERATOR_POLY: poly_q      <= cfg_data_i;
        REG_START_VALUE:    init_q      <= cfg_data_i;
        REG_OUT_XOR:        xor_q       <= cfg_data_i;
        REG_REFLECT_IN:     refl_in_q   <= cfg_data_i[0];
        REG_REFLECT_OUT:    refl_out_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign mask = width_mask(width_sel_q);

  always_comb begin
    for (int i = 0; i < ByteW; i++) begin
      rev_byte[i] = in_data_i.data_byte[ByteW-1-i];
    end
  end

  always_comb begin
    item_o.data_byte = refl_in_q ? rev_byte : in_data_i.data_byte;
    item_o.last_byte = in_data_i.last_byte;

    cfg_o.width_sel   = width_sel_q;
    cfg_o.mask        = mask;
    cfg_o.poly        = poly_q & mask;
    cfg_o.init        = init_q & mask;
    cfg_o.xor_out     = xor_q;
    cfg_o.reflect_out = refl_out_q;
    if (poly_q == '0) begin
      cfg_o.status = STATUS_ZERO_POLY;
    end else if ((poly_q & ~mask) != '0) begin
      cfg_o.status = STATUS_POLY_WIDE;
    end else if ((init_q & ~mask) != '0) begin
      cfg_o.status = STATUS_INIT_WIDE;
    end else if ((xor_q & ~mask) != '0) begin
      cfg_o.status = STATUS_XOR_WIDE;
    end else begin
      cfg_o.status = STATUS_OK;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ccrc_queue.sv
// Two-entry item queue between the front and the back of the CRC engine.
// Depends on ccrc_pkg.
`default_nettype none

module ccrc_queue import ccrc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire ccrc_item_t push_item_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output ccrc_item_t      item_o
);

  ccrc_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ccrc_back.sv
// Back of the CRC engine: running remainder with an eight-step shift/XOR update
// per byte, frame tracking and the registered result stage. Depends on ccrc_pkg.
`default_nettype none

module ccrc_back import ccrc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ccrc_cfg_t  cfg_i,
  input  wire logic       q_valid_i,
  input  wire ccrc_item_t q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output ccrc_out_t       out_data_o
);

  logic [CrcW-1:0] rem_q, rem_d;
  logic            open_q;
  logic            out_valid_q;
  ccrc_out_t       out_q, out_d;
  logic [CrcW-1:0] rem_start;
  logic [CrcW-1:0] rem_next;
  logic [CrcW-1:0] rev_full;
  logic [CrcW-1:0] rev_w;
  logic [CrcW-1:0] crc;
  logic            top;
  logic            out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign q_pop_o     = q_valid_i && (!q_item_i.last_byte || out_free);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    rem_start = open_q ? rem_q : cfg_i.init;
    case (cfg_i.width_sel)
      WIDTH_8:  rem_next = rem_start ^ {24'd0, q_item_i.data_byte};
      WIDTH_16: rem_next = rem_start ^ {16'd0, q_item_i.data_byte, 8'd0};
      default:  rem_next = rem_start ^ {q_item_i.data_byte, 24'd0};
    endcase
    for (int i = 0; i < ByteW; i++) begin
      case (cfg_i.width_sel)
        WIDTH_8:  top = rem_next[7];
        WIDTH_16: top = rem_next[15];
        default:  top = rem_next[31];
      endcase
      rem_next = ({rem_next[CrcW-2:0], 1'b0} ^ (top ? cfg_i.poly : '0)) & cfg_i.mask;
    end
    rem_d = rem_next;
  end

  always_comb begin
    for (int i = 0; i < CrcW; i++) begin
      rev_full[i] = rem_d[CrcW-1-i];
    end
    case (cfg_i.width_sel)
      WIDTH_8:  rev_w = rev_full >> 24;
      WIDTH_16: rev_w = rev_full >> 16;
      default:  rev_w = rev_full;
    endcase
    crc = ((cfg_i.reflect_out ? rev_w : rem_d) ^ cfg_i.xor_out) & cfg_i.mask;
    out_d.crc_value     = (cfg_i.status == STATUS_OK) ? crc : '0;
    out_d.config_status = cfg_i.status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        rem_q  <= q_item_i.last_byte ? cfg_i.init : rem_d;
        open_q <= !q_item_i.last_byte;
      end
      if (q_pop_o && q_item_i.last_byte) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_item_i.last_byte) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/configurable_crc_engine.sv
// Top level of the configurable CRC engine (8, 16 or 32 bit, MSB-first).
// Depends on ccrc_pkg, ccrc_front, ccrc_queue and ccrc_back.
//
// Usage: each input item carries one frame byte and a last-byte flag. The
// engine folds every byte into a running remainder and, on the last byte of a
// frame, delivers one result item with the finished CRC and a configuration
// status code; other bytes produce no result. The next frame restarts from the
// start value. Configuration registers are written through the cfg port, which
// is always ready; the user must write them only while no frame is in flight,
// as the block does not enforce this. Throughput is one byte per clock unless
// a receiver stall holds a last byte: the whole eight-step shift/XOR update of
// a byte is done combinationally by the back stage, fed from the queue entry.
// After reset the configuration is CRC-16 with polynomial 0x1021, start value
// and output XOR zero, no reflection, and no frame open. When the receiver
// stalls, the result is held in the output register; bytes that produce no
// result keep flowing, and input is stalled once the two-entry queue fills.
`default_nettype none

module configurable_crc_engine import ccrc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CrcW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ccrc_in_t           in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ccrc_out_t               out_data_o
);

  ccrc_item_t push_item;
  ccrc_item_t q_item;
  ccrc_cfg_t  cfg;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  logic       push;

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  ccrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .item_o      (push_item),
    .cfg_o       (cfg)
  );

  ccrc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (q_item)
  );

  ccrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
